// ===== hw/rtl/dts_pkg.sv =====
// ---------------------------------------------------------------------------
// dts_pkg: shared types, constants and DFA tables for the token scanner
// Holds the token kind codes, DFA state codes, the transition function and
// the kind-per-state table used by the maximal-munch scanner.
// ---------------------------------------------------------------------------
package dts_pkg;

  // Longest token counted exactly; longer tokens saturate and flag a clip
  localparam int MAX_LEXEME = 255;
  localparam int LEN_W      = $clog2(MAX_LEXEME + 1);

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 5;
  localparam int STATE_W = 5;
  localparam int OUT_LEN_W = 8;
  localparam logic [16:0] OUT_LEN_MAX = 17'd255;

  // Special bytes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;

  // Token kinds
  localparam logic [KIND_W-1:0] K_EOF       = 5'd0;
  localparam logic [KIND_W-1:0] K_SYMBOL    = 5'd1;
  localparam logic [KIND_W-1:0] K_NUMBER    = 5'd2;
  localparam logic [KIND_W-1:0] K_STRING    = 5'd3;
  localparam logic [KIND_W-1:0] K_ASSIGN    = 5'd4;
  localparam logic [KIND_W-1:0] K_MAP       = 5'd5;
  localparam logic [KIND_W-1:0] K_ADD       = 5'd6;
  localparam logic [KIND_W-1:0] K_MUL       = 5'd7;
  localparam logic [KIND_W-1:0] K_EXP       = 5'd8;
  localparam logic [KIND_W-1:0] K_REL       = 5'd9;
  localparam logic [KIND_W-1:0] K_NOT       = 5'd10;
  localparam logic [KIND_W-1:0] K_DOLLAR    = 5'd11;
  localparam logic [KIND_W-1:0] K_ELLIPSE   = 5'd12;
  localparam logic [KIND_W-1:0] K_DOT       = 5'd13;
  localparam logic [KIND_W-1:0] K_COMMA     = 5'd14;
  localparam logic [KIND_W-1:0] K_COLON     = 5'd15;
  localparam logic [KIND_W-1:0] K_SEMICOLON = 5'd16;
  localparam logic [KIND_W-1:0] K_LPAREN    = 5'd17;
  localparam logic [KIND_W-1:0] K_RPAREN    = 5'd18;
  localparam logic [KIND_W-1:0] K_LBRACK    = 5'd19;
  localparam logic [KIND_W-1:0] K_RBRACK    = 5'd20;
  localparam logic [KIND_W-1:0] K_LBRACE    = 5'd21;
  localparam logic [KIND_W-1:0] K_RBRACE    = 5'd22;
  localparam logic [KIND_W-1:0] K_ERROR     = 5'd23;

  // DFA states; the start state doubles as "no transition"
  localparam logic [STATE_W-1:0] S_START   = 5'd0;
  localparam logic [STATE_W-1:0] S_SYMBOL  = 5'd1;
  localparam logic [STATE_W-1:0] S_INT     = 5'd2;
  localparam logic [STATE_W-1:0] S_INT_DOT = 5'd3;
  localparam logic [STATE_W-1:0] S_FRAC    = 5'd4;
  localparam logic [STATE_W-1:0] S_ZERO    = 5'd5;
  localparam logic [STATE_W-1:0] S_STR     = 5'd6;
  localparam logic [STATE_W-1:0] S_STR_END = 5'd7;
  localparam logic [STATE_W-1:0] S_COLON   = 5'd8;
  localparam logic [STATE_W-1:0] S_SEMI    = 5'd9;
  localparam logic [STATE_W-1:0] S_ASSIGN  = 5'd10;
  localparam logic [STATE_W-1:0] S_DOLLAR  = 5'd11;
  localparam logic [STATE_W-1:0] S_PLUS    = 5'd12;
  localparam logic [STATE_W-1:0] S_MINUS   = 5'd13;
  localparam logic [STATE_W-1:0] S_MAP     = 5'd14;
  localparam logic [STATE_W-1:0] S_MUL     = 5'd15;
  localparam logic [STATE_W-1:0] S_EXP     = 5'd16;
  localparam logic [STATE_W-1:0] S_NOT     = 5'd17;
  localparam logic [STATE_W-1:0] S_REL     = 5'd18;
  localparam logic [STATE_W-1:0] S_REL_EQ  = 5'd19;
  localparam logic [STATE_W-1:0] S_LPAREN  = 5'd20;
  localparam logic [STATE_W-1:0] S_RPAREN  = 5'd21;
  localparam logic [STATE_W-1:0] S_LBRACK  = 5'd22;
  localparam logic [STATE_W-1:0] S_RBRACK  = 5'd23;
  localparam logic [STATE_W-1:0] S_LBRACE  = 5'd24;
  localparam logic [STATE_W-1:0] S_RBRACE  = 5'd25;
  localparam logic [STATE_W-1:0] S_COMMA   = 5'd26;
  localparam logic [STATE_W-1:0] S_DOT     = 5'd27;
  localparam logic [STATE_W-1:0] S_ELLIPSE = 5'd28;
  localparam logic [STATE_W-1:0] S_NONE    = S_START;

  // One result beat
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [OUT_LEN_W-1:0] len;
    logic                 clip;
    logic                 last;
  } token_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] b);
    return (b inside {["A":"Z"], ["a":"z"], "_"});
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] b);
    return (b inside {["0":"9"]});
  endfunction

  // Transition function; S_NONE means the byte ends the token
  function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] s,
                                                     input logic [CHAR_W-1:0]  b);
    logic [STATE_W-1:0] t;
    t = S_NONE;
    case (s)
      S_START: begin
        if (is_letter(b))   t = S_SYMBOL;
        else if (b == "0")  t = S_ZERO;
        else if (is_digit(b)) t = S_INT;
        else begin
          case (b)
            CH_QUOTE:           t = S_STR;
            ":":                t = S_COLON;
            ";":                t = S_SEMI;
            "=":                t = S_ASSIGN;
            "$":                t = S_DOLLAR;
            "+":                t = S_PLUS;
            "-":                t = S_MINUS;
            "*", "/", "@", "&": t = S_MUL;
            "^":                t = S_EXP;
            "!":                t = S_NOT;
            "<", ">":           t = S_REL;
            "(":                t = S_LPAREN;
            ")":                t = S_RPAREN;
            "[":                t = S_LBRACK;
            "]":                t = S_RBRACK;
            "{":                t = S_LBRACE;
            "}":                t = S_RBRACE;
            ",":                t = S_COMMA;
            ".":                t = S_DOT;
            default:            t = S_NONE;
          endcase
        end
      end
      S_SYMBOL:  t = (is_letter(b) || is_digit(b)) ? S_SYMBOL : S_NONE;
      S_INT:     t = is_digit(b) ? S_INT : ((b == ".") ? S_INT_DOT : S_NONE);
      S_INT_DOT: t = is_digit(b) ? S_FRAC : S_NONE;
      S_FRAC:    t = is_digit(b) ? S_FRAC : S_NONE;
      S_ZERO:    t = (b == ".") ? S_INT_DOT : S_NONE;
      S_STR: begin
        if (b == CH_NUL)        t = S_NONE;
        else if (b == CH_QUOTE) t = S_STR_END;
        else                    t = S_STR;
      end
      S_MINUS:   t = (b == ">") ? S_MAP : S_NONE;
      S_ASSIGN, S_NOT, S_REL: t = (b == "=") ? S_REL_EQ : S_NONE;
      S_DOT:     t = (b == ".") ? S_ELLIPSE : S_NONE;
      default:   t = S_NONE;
    endcase
    return t;
  endfunction

  // Token kind reported when a token ends in state s
  function automatic logic [KIND_W-1:0] kind_of_state(input logic [STATE_W-1:0] s);
    logic [KIND_W-1:0] k;
    case (s)
      S_SYMBOL:              k = K_SYMBOL;
      S_INT, S_FRAC, S_ZERO: k = K_NUMBER;
      S_STR_END:             k = K_STRING;
      S_COLON:               k = K_COLON;
      S_SEMI:                k = K_SEMICOLON;
      S_ASSIGN:              k = K_ASSIGN;
      S_DOLLAR:              k = K_DOLLAR;
      S_PLUS, S_MINUS:       k = K_ADD;
      S_MAP:                 k = K_MAP;
      S_MUL:                 k = K_MUL;
      S_EXP:                 k = K_EXP;
      S_NOT:                 k = K_NOT;
      S_REL, S_REL_EQ:       k = K_REL;
      S_LPAREN:              k = K_LPAREN;
      S_RPAREN:              k = K_RPAREN;
      S_LBRACK:              k = K_LBRACK;
      S_RBRACK:              k = K_RBRACK;
      S_LBRACE:              k = K_LBRACE;
      S_RBRACE:              k = K_RBRACE;
      S_COMMA:               k = K_COMMA;
      S_DOT:                 k = K_DOT;
      S_ELLIPSE:             k = K_ELLIPSE;
      default:               k = K_ERROR;
    endcase
    return k;
  endfunction

  // Clamp an internal length to the output field
  function automatic logic [OUT_LEN_W-1:0] sat_len(input logic [LEN_W-1:0] n);
    logic [16:0] wide;
    wide = 17'(n);
    return (wide > OUT_LEN_MAX) ? OUT_LEN_MAX[OUT_LEN_W-1:0] : wide[OUT_LEN_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/dfa_token_scanner_top.sv =====
// ---------------------------------------------------------------------------
// dfa_token_scanner_top: maximal-munch token scanner
// Takes one source byte per beat, steps the 29-state DFA and queues the
// zero, one or two token beats that the byte finishes.
// ---------------------------------------------------------------------------
// A token beat enters the result queue when the byte that ends it is taken.
// Throughput: one byte per cycle unless in_stall; the queue drains one beat per cycle
//   unless out_stall, so a byte that ends two tokens (token then EOF or error) is absorbed.
// Input stalls while fewer than two queue entries are free.
// Reset: synchronous; clears the DFA to the start state, leaves comment
//   mode and empties the result queue.
module dfa_token_scanner_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dts_pkg::CHAR_W-1:0]       char_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dts_pkg::KIND_W-1:0]       token_kind,
  output logic [dts_pkg::OUT_LEN_W-1:0]    token_length,
  output logic                             length_clipped,
  output logic                             last
);
  import dts_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Scanner state
  logic [STATE_W-1:0] scan_state, scan_state_next;
  logic               in_comment, in_comment_next;
  logic [LEN_W-1:0]   length_count, length_count_next;
  logic               clip_flag, clip_flag_next;

  // Result queue
  token_t             queue [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  logic               in_fire, out_fire;
  logic [STATE_W-1:0] step_t, start_t;
  logic               tok_valid, start_valid;
  token_t             tok_beat, start_beat;
  logic [1:0]         push_n;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (count > QCNT_W'(QDEPTH - 2));

  assign step_t  = next_state(scan_state, char_in);
  assign start_t = next_state(S_START, char_in);

  // Step the DFA and build the beats this byte finishes
  always_comb begin
    scan_state_next   = scan_state;
    in_comment_next   = in_comment;
    length_count_next = length_count;
    clip_flag_next    = clip_flag;
    tok_valid         = 1'b0;
    start_valid       = 1'b0;
    tok_beat          = '{kind: kind_of_state(scan_state), len: sat_len(length_count),
                          clip: clip_flag, last: 1'b0};
    start_beat        = '{kind: K_EOF, len: '0, clip: 1'b0, last: 1'b1};

    if (in_comment) begin
      if (char_in == CH_NL) begin
        in_comment_next = 1'b0;
      end else if (char_in == CH_NUL) begin
        in_comment_next = 1'b0;
        start_valid     = 1'b1;
      end
    end else if (char_in == CH_HASH) begin
      scan_state_next   = S_START;
      length_count_next = '0;
      clip_flag_next    = 1'b0;
      in_comment_next   = 1'b1;
    end else if (scan_state != S_START && step_t != S_NONE) begin
      // grow the partial token
      scan_state_next = step_t;
      if (length_count < LEN_W'(MAX_LEXEME)) begin
        length_count_next = length_count + 1'b1;
      end else begin
        clip_flag_next = 1'b1;
      end
    end else begin
      // close the partial token, then rescan the byte from the start
      tok_valid         = (scan_state != S_START);
      scan_state_next   = S_START;
      length_count_next = '0;
      clip_flag_next    = 1'b0;
      if (char_in == CH_SP || char_in == CH_TAB || char_in == CH_NL) begin
        start_valid = 1'b0;
      end else if (char_in == CH_NUL) begin
        start_valid = 1'b1;
      end else if (start_t == S_NONE) begin
        start_valid = 1'b1;
        start_beat  = '{kind: K_ERROR, len: OUT_LEN_W'(1), clip: 1'b0, last: 1'b1};
      end else begin
        scan_state_next   = start_t;
        length_count_next = LEN_W'(1);
      end
    end
    tok_beat.last = !start_valid;
    push_n = 2'(tok_valid) + 2'(start_valid);
  end

  // Hold scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state   <= S_START;
      in_comment   <= 1'b0;
      length_count <= '0;
      clip_flag    <= 1'b0;
    end else if (in_fire) begin
      scan_state   <= scan_state_next;
      in_comment   <= in_comment_next;
      length_count <= length_count_next;
      clip_flag    <= clip_flag_next;
    end
  end

  // Push finished beats in order
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (tok_valid) begin
        queue[wr_ptr] <= tok_beat;
        if (start_valid) begin
          queue[wr_ptr + 1'b1] <= start_beat;
        end
      end else if (start_valid) begin
        queue[wr_ptr] <= start_beat;
      end
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + QPTR_W'(push_n);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(in_fire ? push_n : 2'd0) - QCNT_W'(out_fire);
    end
  end

  assign out_valid      = (count != '0);
  assign token_kind     = queue[rd_ptr].kind;
  assign token_length   = queue[rd_ptr].len;
  assign length_clipped = queue[rd_ptr].clip;
  assign last           = queue[rd_ptr].last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_comment_clear: assert property (@(posedge clk) disable iff (rst)
    in_comment |-> (scan_state == S_START && length_count == '0))
    else $error("partial token left while in comment");

  a_token_len: assert property (@(posedge clk) disable iff (rst)
    (scan_state != S_START) |-> (length_count != '0))
    else $error("open token with zero length");

  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_kind == K_EOF) |-> (token_length == '0 && !length_clipped && last))
    else $error("malformed EOF beat");

  a_pair_fits: assert property (@(posedge clk) disable iff (rst)
    (in_fire && push_n == 2'd2) |=> (count >= 3'(1)))
    else $error("two-beat byte lost a beat");

endmodule
